@@ design/servo_duty_ramp_top_macros.svh @@
// Assertion macros shared by the servo duty ramp RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SERVO_DUTY_RAMP_TOP_MACROS_SVH
`define SERVO_DUTY_RAMP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define SDR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo duty ramp check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo duty ramp check failed");

`else

`define SDR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SDR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/sdr_pkg.sv @@
// Shared types and constants of the servo duty ramp.
// No dependencies; used by the controller, the datapath and the top level.
package sdr_pkg;

   localparam int DUTY_W = 14;
   localparam int TICK_W = 16;
   localparam int ERR_W  = 16;
   // The error magnitude never exceeds the duty range, so the quotient fits it.
   localparam int DIV_W  = 14;
   localparam int CNT_W  = $clog2(DIV_W);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_FORCE = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic div_step;
      logic apply;
   } sdr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
   } sdr_sts_type;

endpackage

@@ design/servo_duty_ramp_top.sv @@
// Servo duty ramp top level: one transaction in flight, one result per transaction.
// Tick, force and no-op are applied straight after accept; start first runs the serial
// divider, one quotient bit per cycle for 14 bits, then applies. The result is registered
// on apply. A stalled result delays the apply of the next transaction. Synchronous
// active-high reset: duty 0, not moving, no result pending. Depends on sdr_pkg,
// sdr_ctrl and sdr_dpath.
module servo_duty_ramp_top #(
   parameter int DUTY_MAX = 10000
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [sdr_pkg::DUTY_W-1:0] req_target_duty,
   input  logic [sdr_pkg::TICK_W-1:0] req_ramp_ticks,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [sdr_pkg::DUTY_W-1:0] rsp_duty,
   output logic                       rsp_moving,
   output logic                       rsp_rejected
);
   import sdr_pkg::*;

   sdr_cmd_type cmd;
   sdr_sts_type sts;

   sdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   sdr_dpath #(
      .DUTY_MAX (DUTY_MAX)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_target_duty (req_target_duty),
      .req_ramp_ticks  (req_ramp_ticks),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_duty        (rsp_duty),
      .rsp_moving      (rsp_moving),
      .rsp_rejected    (rsp_rejected)
   );

endmodule

@@ design/sdr_ctrl.sv @@
// Controller of the servo duty ramp: sequences latch, divide and apply.
// Depends on sdr_pkg and servo_duty_ramp_top_macros.svh.
`include "servo_duty_ramp_top_macros.svh"

module sdr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sdr_pkg::sdr_cmd_type cmd,
   input  sdr_pkg::sdr_sts_type sts
);
   import sdr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   // Decode handshakes and commands
   always_comb begin
      accept       = req_valid && (state_ff == S_IDLE);
      out_free     = !rsp_valid_ff || !rsp_stall;
      cmd.latch    = accept;
      cmd.div_step = (state_ff == S_DIVIDE);
      cmd.apply    = (state_ff == S_APPLY) && out_free;
   end

   // Advance the sequence
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (opcode_type'(req_opcode) == OP_START) ? S_DIVIDE : S_APPLY;
            end
         end
         S_DIVIDE: begin
            if (sts.div_last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SDR_ASSERT_NEXT(a_apply_gives_result, clock, reset, cmd.apply, rsp_valid_ff)
   `SDR_ASSERT_NEXT(a_start_divides, clock, reset,
      accept && (opcode_type'(req_opcode) == OP_START), state_ff == S_DIVIDE)
   `SDR_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, req_stall)
   `SDR_ASSERT_NEXT(a_divide_holds, clock, reset,
      (state_ff == S_DIVIDE) && !sts.div_last, state_ff == S_DIVIDE)

endmodule

@@ design/sdr_dpath.sv @@
// Datapath of the servo duty ramp: ramp state, serial divider, result register.
// Depends on sdr_pkg and servo_duty_ramp_top_macros.svh.
`include "servo_duty_ramp_top_macros.svh"

module sdr_dpath #(
   parameter int DUTY_MAX = 10000
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_opcode,
   input  logic [sdr_pkg::DUTY_W-1:0]    req_target_duty,
   input  logic [sdr_pkg::TICK_W-1:0]    req_ramp_ticks,
   input  sdr_pkg::sdr_cmd_type          cmd,
   output sdr_pkg::sdr_sts_type          sts,
   output logic [sdr_pkg::DUTY_W-1:0]    rsp_duty,
   output logic                          rsp_moving,
   output logic                          rsp_rejected
);
   import sdr_pkg::*;

   localparam logic [DUTY_W-1:0] DUTY_TOP = DUTY_W'(DUTY_MAX - 1);
   localparam logic signed [DUTY_W+2:0] DUTY_LIM = (DUTY_W+3)'(DUTY_MAX);

   // Architectural ramp state
   logic [DUTY_W-1:0]        cur_ff, cur_in;
   logic [DUTY_W-1:0]        goal_ff, goal_in;
   logic signed [ERR_W-1:0]  step_ff, step_in;
   logic signed [ERR_W-1:0]  rerr_ff, rerr_in;
   logic                     active_ff, active_in;

   // Latched transaction and divider
   opcode_type               op_ff;
   logic [DUTY_W-1:0]        tgt_ff;
   logic [TICK_W-1:0]        ticks_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [DIV_W-1:0]         num_ff, num_in;
   logic [TICK_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff;

   // Result register
   logic [DUTY_W-1:0]        rsp_duty_ff;
   logic                     rsp_moving_ff;
   logic                     rsp_rejected_ff;

   logic signed [ERR_W-1:0]  err_new;
   logic [DIV_W-1:0]         mag_new;
   logic [TICK_W:0]          rem_sh;
   logic                     ge;
   logic signed [ERR_W-1:0]  quot_s;
   logic signed [ERR_W-1:0]  err_tick;
   logic                     crossed;
   logic signed [DUTY_W+2:0] duty_sum;
   logic                     rej;

   // Form the signed error and its magnitude for the divider
   always_comb begin
      err_new = $signed({2'b00, req_target_duty}) - $signed({2'b00, cur_ff});
      mag_new = err_new[ERR_W-1] ? DIV_W'(-err_new) : DIV_W'(err_new);
   end

   // One restoring division step per cycle
   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_W-1]};
      ge     = (rem_sh >= {1'b0, ticks_ff});
      rem_in = ge ? TICK_W'(rem_sh - {1'b0, ticks_ff}) : TICK_W'(rem_sh);
      num_in = {num_ff[DIV_W-2:0], ge};
   end

   assign sts.div_last = (cnt_ff == CNT_W'(DIV_W - 1));

   // Latch the transaction and run the divider
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= opcode_type'(req_opcode);
         tgt_ff   <= req_target_duty;
         ticks_ff <= (req_ramp_ticks == '0) ? TICK_W'(1) : req_ramp_ticks;
         err_ff   <= err_new;
         num_ff   <= mag_new;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Compute the state update for the latched transaction
   always_comb begin
      cur_in    = cur_ff;
      goal_in   = goal_ff;
      step_in   = step_ff;
      rerr_in   = rerr_ff;
      active_in = active_ff;
      rej       = 1'b0;
      quot_s    = err_ff[ERR_W-1] ? -$signed({2'b00, num_ff}) : $signed({2'b00, num_ff});
      err_tick  = rerr_ff - step_ff;
      crossed   = (step_ff[ERR_W-1] && !err_tick[ERR_W-1]) ||
                  (!step_ff[ERR_W-1] && (step_ff != '0) &&
                   (err_tick[ERR_W-1] || (err_tick == '0)));
      duty_sum  = $signed({3'b000, cur_ff}) + $signed({step_ff[ERR_W-1], step_ff});
      unique case (op_ff)
         OP_START: begin
            goal_in   = tgt_ff;
            rerr_in   = err_ff;
            active_in = 1'b1;
            if (num_ff == '0) begin
               step_in = (!err_ff[ERR_W-1] && (err_ff != '0)) ? ERR_W'(1) : -ERR_W'(1);
            end else begin
               step_in = quot_s;
            end
         end
         OP_TICK: begin
            if (active_ff) begin
               if (crossed) begin
                  active_in = 1'b0;
                  rerr_in   = '0;
                  cur_in    = goal_ff;
               end else begin
                  rerr_in = err_tick;
                  // Saturate the advanced duty to the legal range
                  priority if (duty_sum[DUTY_W+2]) begin
                     cur_in = '0;
                  end else if (duty_sum >= DUTY_LIM) begin
                     cur_in = DUTY_TOP;
                  end else begin
                     cur_in = duty_sum[DUTY_W-1:0];
                  end
               end
            end
         end
         OP_FORCE: begin
            if (active_ff) begin
               rej = 1'b1;
            end else begin
               cur_in = tgt_ff;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // Commit the ramp state on apply
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         goal_ff   <= '0;
         step_ff   <= '0;
         rerr_ff   <= '0;
         active_ff <= 1'b0;
      end else if (cmd.apply) begin
         cur_ff    <= cur_in;
         goal_ff   <= goal_in;
         step_ff   <= step_in;
         rerr_ff   <= rerr_in;
         active_ff <= active_in;
      end
   end

   // Load the result register on apply
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_duty_ff     <= cur_in;
         rsp_moving_ff   <= active_in;
         rsp_rejected_ff <= rej;
      end
   end

   assign rsp_duty     = rsp_duty_ff;
   assign rsp_moving   = rsp_moving_ff;
   assign rsp_rejected = rsp_rejected_ff;

   `SDR_ASSERT_IMPL(a_moving_step_nonzero, clock, reset, active_ff, step_ff != '0)
   `SDR_ASSERT_IMPL(a_idle_error_clear, clock, reset, !active_ff, rerr_ff == '0)
   `SDR_ASSERT_NEXT(a_cross_snaps_goal, clock, reset,
      cmd.apply && (op_ff == OP_TICK) && active_ff && crossed,
      (cur_ff == $past(goal_ff)) && !active_ff)

endmodule
